>>> src/lcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared codes, widths and controller/datapath interface types for the
// longest common subsequence length unit.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;

    typedef logic [CMD_W-1:0] t_cmd_code;

    localparam t_cmd_code CMD_LOAD   = 2'd0;
    localparam t_cmd_code CMD_SWEEP  = 2'd1;
    localparam t_cmd_code CMD_FINISH = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic b_load;       // store value at b_count, or flag overflow when full
        logic a_capture;    // latch A element, restart sweep pointers
        logic sweep_issue;  // read B entry and row cell at sweep index
        logic fin_read;     // read final row cell
        logic fin_emit;     // load output register, clear count/fill/flag
    } t_dp_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic b_empty;
        logic idx_last;     // sweep index is the last loaded B position
        logic pipe_busy;    // a read is in the compute stage
        logic out_free;     // output register can take a result this cycle
    } t_dp_stat;

endpackage
`default_nettype wire

>>> src/lcs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_dp
// Datapath: B element store, rolling row store, one-cell-per-cycle sweep
// pipeline and the result register.
// ----------------------------------------------------------------------------
module lcs_dp #(
    parameter int MAX_B_LEN = 1024,
    parameter int ELEM_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lcs_pkg::t_dp_ctrl            i_ctrl,
    output lcs_pkg::t_dp_stat                 o_stat,
    input  wire logic [lcs_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                         i_m_tready,
    output logic                              o_m_tvalid,
    output logic [lcs_pkg::LEN_W-1:0]         o_lcs_length,
    output logic                              o_overflow
);

    localparam int CNT_W = $clog2(MAX_B_LEN + 1);
    localparam int AW    = (MAX_B_LEN > 1) ? $clog2(MAX_B_LEN) : 1;
    localparam int EW    = (ELEM_BITS < lcs_pkg::VALUE_W) ? ELEM_BITS : lcs_pkg::VALUE_W;

    // row cell j (1..MAX_B_LEN) lives at address j-1; cell 0 is always zero
    logic [EW-1:0]    mem_b   [MAX_B_LEN];
    logic [CNT_W-1:0] mem_row [MAX_B_LEN];

    logic [CNT_W-1:0] r_b_count;
    logic [CNT_W-1:0] r_fill;      // row cells at or above this were not written since clear
    logic             r_ovf;
    logic [EW-1:0]    r_a;
    logic [AW-1:0]    r_idx;
    logic             r_s1_valid;
    logic [AW-1:0]    r_s1_idx;
    logic [EW-1:0]    r_b_rd;
    logic [CNT_W-1:0] r_row_rd;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_diag;
    logic             r_fin_zero;
    logic             r_out_valid;
    logic [lcs_pkg::LEN_W-1:0] r_out_len;
    logic             r_out_ovf;

    logic [CNT_W-1:0]       w_last;
    logic [AW-1:0]          w_row_addr;
    logic [CNT_W-1:0]       w_s1_idx;
    logic [CNT_W-1:0]       w_up;
    logic [CNT_W-1:0]       w_max;
    logic [CNT_W-1:0]       w_diag1;
    logic [CNT_W-1:0]       w_cell;
    logic [CNT_W-1:0]       w_len;
    logic [CNT_W+lcs_pkg::LEN_W-1:0] w_len_ext;
    logic                   w_b_full;

    assign w_last     = r_b_count - CNT_W'(1);
    assign w_row_addr = i_ctrl.fin_read ? w_last[AW-1:0] : r_idx;
    assign w_s1_idx   = CNT_W'(r_s1_idx);
    assign w_b_full   = (r_b_count == CNT_W'(MAX_B_LEN));

    // cells never written since the last clear read as zero
    assign w_up    = (w_s1_idx < r_fill) ? r_row_rd : '0;
    assign w_max   = (r_left > w_up) ? r_left : w_up;
    assign w_diag1 = r_diag + CNT_W'(1);
    assign w_cell  = ((r_b_rd == r_a) && (w_diag1 > w_max)) ? w_diag1 : w_max;

    assign w_len     = r_fin_zero ? '0 : r_row_rd;
    assign w_len_ext = (CNT_W + lcs_pkg::LEN_W)'(w_len);

    assign o_stat.b_empty   = (r_b_count == '0);
    assign o_stat.idx_last  = (CNT_W'(r_idx) == w_last);
    assign o_stat.pipe_busy = r_s1_valid;
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid   = r_out_valid;
    assign o_lcs_length = r_out_len;
    assign o_overflow   = r_out_ovf;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctrl.b_load && !w_b_full) begin
            mem_b[r_b_count[AW-1:0]] <= i_value[EW-1:0];
        end
        if (i_ctrl.sweep_issue) begin
            r_b_rd <= mem_b[r_idx];
        end
        if (r_s1_valid) begin
            mem_row[r_s1_idx] <= w_cell;
        end
        if (i_ctrl.sweep_issue || i_ctrl.fin_read) begin
            r_row_rd <= mem_row[w_row_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.a_capture) begin
            r_a    <= i_value[EW-1:0];
            r_idx  <= '0;
            r_left <= '0;
            r_diag <= '0;
        end else begin
            if (i_ctrl.sweep_issue) begin
                r_idx <= r_idx + AW'(1);
            end
            if (r_s1_valid) begin
                r_left <= w_cell;
                r_diag <= w_up;
            end
        end
        if (i_ctrl.sweep_issue) begin
            r_s1_idx <= r_idx;
        end
        if (i_ctrl.fin_read) begin
            r_fin_zero <= (r_b_count == '0) || (r_b_count > r_fill);
        end
        if (i_ctrl.fin_emit) begin
            r_out_len <= w_len_ext[lcs_pkg::LEN_W-1:0];
            r_out_ovf <= r_ovf;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_count   <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctrl.sweep_issue;
            if (i_ctrl.fin_emit) begin
                r_b_count <= '0;
                r_fill    <= '0;
                r_ovf     <= 1'b0;
            end else begin
                if (i_ctrl.b_load) begin
                    if (w_b_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_b_count <= r_b_count + CNT_W'(1);
                    end
                end
                if (r_s1_valid && (w_s1_idx >= r_fill)) begin
                    r_fill <= w_s1_idx + CNT_W'(1);
                end
            end
            if (i_ctrl.fin_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/lcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_ctrl
// Controller: decodes accepted commands and sequences the row sweep and the
// finish read/emit steps of the datapath.
// ----------------------------------------------------------------------------
module lcs_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire lcs_pkg::t_cmd_code    i_cmd,
    output logic                       o_s_tready,
    input  wire lcs_pkg::t_dp_stat     i_stat,
    output lcs_pkg::t_dp_ctrl          o_ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FIN_RD,
        ST_FIN_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd)
                        lcs_pkg::CMD_LOAD: begin
                            o_ctrl.b_load = 1'b1;
                        end
                        lcs_pkg::CMD_SWEEP: begin
                            // empty B leaves the row untouched
                            if (!i_stat.b_empty) begin
                                o_ctrl.a_capture = 1'b1;
                                n_state          = ST_SWEEP;
                            end
                        end
                        lcs_pkg::CMD_FINISH: begin
                            n_state = ST_FIN_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                o_ctrl.sweep_issue = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIN_RD: begin
                o_ctrl.fin_read = 1'b1;
                n_state         = ST_FIN_EMIT;
            end
            ST_FIN_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.fin_emit = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> src/longest_common_subsequence_length_unit.sv
// Load: the controller stays idle, so loads can follow back to back. Process
// A element: one row cell per cycle through the row store port, then a drain
// of the pipeline; with empty B the element is dropped and the controller
// stays idle. Finish: a read state, then an emit state that waits until the
// output register is free; the next transfer is taken back in idle.
// Reset is synchronous, active low; the row store needs no clearing pass, a
// fill mark makes unwritten cells read as zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_common_subsequence_length_unit
// LCS length engine with a rolling one-row dynamic-programming store.
// ----------------------------------------------------------------------------
module longest_common_subsequence_length_unit #(
    parameter int MAX_B_LEN = 1024,
    parameter int ELEM_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [10:0] lcs_length, [11] overflow, [15:12] zero
);

    lcs_pkg::t_dp_ctrl w_ctrl;
    lcs_pkg::t_dp_stat w_stat;
    logic [lcs_pkg::LEN_W-1:0] w_len;
    logic                      w_ovf;

    lcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    lcs_dp #(
        .MAX_B_LEN (MAX_B_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .i_value      (s_axis_tdata),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_lcs_length (w_len),
        .o_overflow   (w_ovf)
    );

    assign m_axis_tdata = {4'b0000, w_ovf, w_len};

endmodule
`default_nettype wire

>>> bench/tb_longest_common_subsequence_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_common_subsequence_length_unit
// Self-checking bench for the LCS length unit. A directed table walks the
// corner cases (empty B, single matches, ignored command, extreme element
// values), then random sequence sets with small alphabets follow.
// Each finish is predicted by the table's fixed expectation or else by a
// rolling-row DP tracker kept in the bench; each output transfer is checked
// against the oldest prediction. Sender and receiver both idle at random.
// ----------------------------------------------------------------------------
module tb_longest_common_subsequence_length_unit;

    localparam int                 MAX_B        = 1024;
    localparam int                 RANDOM_ITEMS = 550;
    localparam lcs_pkg::t_cmd_code CMD_UNUSED   = 2'd3;

    typedef struct packed {
        logic [lcs_pkg::LEN_W-1:0] len;
        logic                      ovf;
    } t_lcs_result;

    typedef struct {
        lcs_pkg::t_cmd_code cmd;
        logic [31:0]        value;
        int                 reps;
        bit                 fixed;
        t_lcs_result        res;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] value
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [10:0] lcs_length, [11] overflow, [15:12] zero

    longest_common_subsequence_length_unit #(
        .MAX_B_LEN(MAX_B),
        .ELEM_BITS(32)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // bench copy of the DP state
    logic [31:0]               b_elems [0:MAX_B-1];
    logic [lcs_pkg::LEN_W-1:0] dp_row  [0:MAX_B];
    int                        b_fill;
    bit                        ovf_seen;

    t_stim_row   plan[$];
    t_lcs_result pending_lengths[$];
    int          error_count = 0;
    int          sent_items  = 0;
    int          burst_left  = 0;
    logic [31:0] alphabet [0:3];

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    task automatic add_row(input lcs_pkg::t_cmd_code cmd, input logic [31:0] value,
                           input int reps, input bit fixed, input t_lcs_result res);
        t_stim_row row;
        row.cmd   = cmd;
        row.value = value;
        row.reps  = reps;
        row.fixed = fixed;
        row.res   = res;
        plan.insert(plan.size(), row);
    endtask

    task automatic expect_result(input t_lcs_result res);
        pending_lengths.insert(pending_lengths.size(), res);
    endtask

    // Applies one accepted command to the tracked row; returns a result on finish.
    task automatic advance_lcs_row(input lcs_pkg::t_cmd_code cmd, input logic [31:0] val,
                                   output bit produced, output t_lcs_result res);
        logic [lcs_pkg::LEN_W-1:0] left;
        logic [lcs_pkg::LEN_W-1:0] diag;
        logic [lcs_pkg::LEN_W-1:0] up;
        logic [lcs_pkg::LEN_W-1:0] best;
        produced = 0;
        res      = '0;
        case (cmd)
            lcs_pkg::CMD_LOAD: begin
                if (b_fill < MAX_B) begin
                    b_elems[b_fill] = val;
                    b_fill++;
                end else begin
                    ovf_seen = 1;
                end
            end
            lcs_pkg::CMD_SWEEP: begin
                left = '0;
                diag = dp_row[0];
                for (int j = 1; j <= b_fill; j++) begin
                    up   = dp_row[j];
                    best = (left > up) ? left : up;
                    if (b_elems[j-1] == val && diag + 1'b1 > best)
                        best = diag + 1'b1;
                    diag      = up;
                    dp_row[j] = best;
                    left      = best;
                end
            end
            lcs_pkg::CMD_FINISH: begin
                produced = 1;
                res.len  = dp_row[b_fill];
                res.ovf  = ovf_seen;
                for (int j = 0; j <= MAX_B; j++)
                    dp_row[j] = '0;
                b_fill   = 0;
                ovf_seen = 0;
            end
            default: ;
        endcase
    endtask

    // Drives one item and holds it until the transfer; idles between bursts.
    task automatic send_item(input lcs_pkg::t_cmd_code cmd, input logic [31:0] val,
                             input bit fixed, input t_lcs_result fixed_res);
        int          gap;
        bit          produced;
        t_lcs_result res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_lcs_row(cmd, val, produced, res);
        if (produced)
            expect_result(fixed ? fixed_res : res);
        if (cmd != CMD_UNUSED)
            sent_items++;
        burst_left--;
    endtask

    function automatic logic [31:0] pick_symbol();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return alphabet[$urandom_range(0, 3)];
    endfunction

    function automatic int draw_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 8);
        if (r < 19)
            return $urandom_range(9, 24);
        return $urandom_range(25, 64);
    endfunction

    // receiver: stall pattern switches at random between its three modes
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_lcs_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_lengths.size() == 0) begin
                report_mismatch("pending results", 0, 1);
            end else begin
                want = pending_lengths.pop_front();
                if (m_axis_tdata[10:0] !== want.len)
                    report_mismatch("lcs_length", m_axis_tdata[10:0], want.len);
                if (m_axis_tdata[11] !== want.ovf)
                    report_mismatch("overflow", m_axis_tdata[11], want.ovf);
                if (m_axis_tdata[15:12] !== 4'd0)
                    report_mismatch("pad bits", m_axis_tdata[15:12], 0);
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_lcs_result none;
        int          base;
        int          b_len;
        int          a_len;
        int          loads_left;
        int          sweeps_left;
        bit          mixed;
        logic [31:0] corner [0:3];

        none   = '0;
        b_fill = 0;
        ovf_seen = 0;
        for (int j = 0; j <= MAX_B; j++)
            dp_row[j] = '0;
        for (int j = 0; j < MAX_B; j++)
            b_elems[j] = '0;
        corner[0] = 32'h8000_0000;
        corner[1] = 32'h7fff_ffff;
        corner[2] = 32'h0000_0000;
        corner[3] = 32'hffff_ffff;

        // cmd, value, repeat, fixed expectation, {len, ovf}
        add_row(lcs_pkg::CMD_FINISH, 32'h0,         1, 1, '{11'd0, 1'b0}); // right after reset
        add_row(lcs_pkg::CMD_SWEEP,  32'h7fff_ffff, 1, 0, none);           // sweep, B empty
        add_row(lcs_pkg::CMD_FINISH, 32'h0,         1, 1, '{11'd0, 1'b0});
        add_row(CMD_UNUSED,          32'hffff_ffff, 1, 0, none);           // ignored command
        add_row(lcs_pkg::CMD_FINISH, 32'h0,         1, 1, '{11'd0, 1'b0});
        add_row(lcs_pkg::CMD_LOAD,   32'h8000_0000, 1, 0, none);
        add_row(lcs_pkg::CMD_LOAD,   32'h7fff_ffff, 1, 0, none);
        add_row(lcs_pkg::CMD_LOAD,   32'h0000_0000, 1, 0, none);
        add_row(lcs_pkg::CMD_LOAD,   32'hffff_ffff, 1, 0, none);
        add_row(lcs_pkg::CMD_SWEEP,  32'hffff_ffff, 1, 0, none);
        add_row(lcs_pkg::CMD_SWEEP,  32'h8000_0000, 1, 0, none);
        add_row(CMD_UNUSED,          32'h1234_5678, 1, 0, none);
        add_row(lcs_pkg::CMD_SWEEP,  32'h7fff_ffff, 1, 0, none);
        add_row(lcs_pkg::CMD_FINISH, 32'hffff_ffff, 1, 0, none);           // value ignored
        add_row(lcs_pkg::CMD_LOAD,   32'h5a5a_5a5a, 3, 0, none);
        add_row(lcs_pkg::CMD_SWEEP,  32'h5a5a_5a5a, 1, 0, none);
        add_row(lcs_pkg::CMD_FINISH, 32'h0,         1, 1, '{11'd1, 1'b0});
        add_row(lcs_pkg::CMD_LOAD,   32'h0000_0001, 3, 0, none);
        add_row(lcs_pkg::CMD_SWEEP,  32'h0000_0002, 1, 0, none);           // no match
        add_row(lcs_pkg::CMD_FINISH, 32'h0,         1, 1, '{11'd0, 1'b0});
        add_row(lcs_pkg::CMD_LOAD,   32'h0000_0009, 1, 0, none);
        add_row(lcs_pkg::CMD_FINISH, 32'h0,         1, 1, '{11'd0, 1'b0}); // no sweep

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r])
            repeat (plan[r].reps)
                send_item(plan[r].cmd, plan[r].value, plan[r].fixed, plan[r].res);

        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS) begin
            for (int k = 0; k < 4; k++)
                alphabet[k] = ($urandom_range(0, 4) == 0) ? corner[$urandom_range(0, 3)]
                                                          : $urandom;
            // fewer distinct symbols now and then, so matches get dense
            if ($urandom_range(0, 2) == 0)
                alphabet[2] = alphabet[0];
            b_len = draw_len();
            a_len = draw_len();
            mixed = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 7) == 0)
                send_item(CMD_UNUSED, $urandom, 0, none);
            if (mixed) begin
                // loads and sweeps interleaved, B grows under a partly swept row
                loads_left  = b_len;
                sweeps_left = a_len;
                while (loads_left + sweeps_left > 0) begin
                    if (sweeps_left == 0 || (loads_left > 0 && $urandom_range(0, 1))) begin
                        send_item(lcs_pkg::CMD_LOAD, pick_symbol(), 0, none);
                        loads_left--;
                    end else begin
                        send_item(lcs_pkg::CMD_SWEEP, pick_symbol(), 0, none);
                        sweeps_left--;
                    end
                    if ($urandom_range(0, 15) == 0)
                        send_item(CMD_UNUSED, $urandom, 0, none);
                end
            end else begin
                repeat (b_len) send_item(lcs_pkg::CMD_LOAD, pick_symbol(), 0, none);
                repeat (a_len) send_item(lcs_pkg::CMD_SWEEP, pick_symbol(), 0, none);
            end
            if ($urandom_range(0, 9) != 0)
                send_item(lcs_pkg::CMD_FINISH, $urandom, 0, none);
        end
        send_item(lcs_pkg::CMD_FINISH, $urandom, 0, none);
        s_axis_tvalid <= 1'b0;

        while (pending_lengths.size() != 0)
            @(posedge i_clk);
        repeat (MAX_B + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> longest_common_subsequence_length_unit.f
src/lcs_pkg.sv
src/lcs_dp.sv
src/lcs_ctrl.sv
src/longest_common_subsequence_length_unit.sv
bench/tb_longest_common_subsequence_length_unit.sv
